### rtl/usbep_pkg.sv
`timescale 1ns / 1ps
package usbep_pkg;

    typedef enum logic [3:0] {
        CMD_OPEN      = 4'd0,
        CMD_CLOSE     = 4'd1,
        CMD_STALL     = 4'd2,
        CMD_CLR_STALL = 4'd3,
        CMD_CANCEL    = 4'd4,
        CMD_SUBMIT_IN = 4'd5,
        CMD_SUBMIT_OUT = 4'd6,
        CMD_SET_ADDR  = 4'd7,
        CMD_IN_DONE   = 4'd8,
        CMD_OUT_RX    = 4'd9,
        CMD_SETUP     = 4'd10,
        CMD_BUS_RESET = 4'd11
    } t_cmd;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_INVALID     = 3'd1;
    localparam logic [2:0] ST_NOT_READY   = 3'd2;
    localparam logic [2:0] ST_BUSY        = 3'd3;
    localparam logic [2:0] ST_UNSUPPORTED = 3'd4;

    localparam logic [2:0] EV_NONE     = 3'd0;
    localparam logic [2:0] EV_COMPLETE = 3'd1;
    localparam logic [2:0] EV_INVALID  = 3'd2;
    localparam logic [2:0] EV_SETUP    = 3'd3;
    localparam logic [2:0] EV_RESET    = 3'd4;

    localparam logic [1:0] HS_ACK   = 2'd0;
    localparam logic [1:0] HS_NAK   = 2'd1;
    localparam logic [1:0] HS_STALL = 2'd2;

    localparam logic [1:0] KIND_CONTROL = 2'd0;
    localparam logic [1:0] KIND_ISO     = 2'd1;
    localparam logic [1:0] KIND_BULK    = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_OUT
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic load;
        logic exec;
    } t_dp_cmd;

    function automatic logic pow2_packet(input logic [9:0] v);
        return v == 10'd8 || v == 10'd16 || v == 10'd32 || v == 10'd64;
    endfunction

endpackage

### rtl/usb_endpoint_transfer_engine_unit.sv
`timescale 1ns / 1ps
// Channel   | Handshake              | Payload
// ----------+------------------------+-------------------------------------------
// command   | i_valid / o_ready      | i_cmd, endpoint, size and token fields
// result    | o_valid / i_ready      | o_status, o_event_kind ... o_buffer_offset
// config    | i_cfg_we (no wait)     | i_cfg_data (endpoint zero max packet)
//
// Each command word is captured, then executed against the endpoint state
// in the execute state, and the result register is shown the next cycle.
// A new word is taken in the same cycle the previous result is taken, and
// not before, so the engine never holds two words at once.
// Reset is synchronous and active low; it restores the endpoint-zero defaults.
// A stalled result holds the engine; no word is taken until it drains.
module usb_endpoint_transfer_engine_unit #(
    parameter int ENDPOINT_COUNT = 8,
    parameter int MAX_PACKET     = 64,
    parameter int LENGTH_BITS    = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [3:0]  i_cmd,
    input  logic [7:0]  i_endpoint_address,
    input  logic [7:0]  i_endpoint_number,
    input  logic [1:0]  i_endpoint_type,
    input  logic [15:0] i_transfer_size,
    input  logic [9:0]  i_packet_size,
    input  logic [7:0]  i_rx_length,
    input  logic        i_toggle_ok,
    input  logic [7:0]  i_new_address,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [2:0]  o_event_kind,
    output logic [7:0]  o_event_endpoint_address,
    output logic [15:0] o_transferred_count,
    output logic [1:0]  o_handshake,
    output logic [6:0]  o_in_packet_len,
    output logic        o_data_toggle,
    output logic [6:0]  o_device_address,
    output logic [15:0] o_buffer_offset
);

    usbep_pkg::t_dp_cmd dp_cmd;

    usbep_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (dp_cmd)
    );

    usbep_dp #(
        .EP_COUNT (ENDPOINT_COUNT),
        .MAX_PKT  (MAX_PACKET),
        .LEN_BITS (LENGTH_BITS)
    ) u_dp (
        .i_clk                    (i_clk),
        .i_rst_n                  (i_rst_n),
        .i_cmd                    (dp_cmd),
        .i_cfg_we                 (i_cfg_we),
        .i_cfg_data               (i_cfg_data),
        .i_cmd_code               (i_cmd),
        .i_endpoint_address       (i_endpoint_address),
        .i_endpoint_number        (i_endpoint_number),
        .i_endpoint_type          (i_endpoint_type),
        .i_transfer_size          (i_transfer_size),
        .i_packet_size            (i_packet_size),
        .i_rx_length              (i_rx_length),
        .i_toggle_ok              (i_toggle_ok),
        .i_new_address            (i_new_address),
        .o_status                 (o_status),
        .o_event_kind             (o_event_kind),
        .o_event_endpoint_address (o_event_endpoint_address),
        .o_transferred_count      (o_transferred_count),
        .o_handshake              (o_handshake),
        .o_in_packet_len          (o_in_packet_len),
        .o_data_toggle            (o_data_toggle),
        .o_device_address         (o_device_address),
        .o_buffer_offset          (o_buffer_offset)
    );

`ifndef SYNTHESIS
    // An accepted word always produces a result after its execute state.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> ##1 o_valid)
        else $error("result missing after accepted word");
    // The engine never takes a word while a result is pending and not taken.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |-> !o_ready)
        else $error("word accepted over a pending result");
    // A bus reset always reports address zero.
    a_reset_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_event_kind == usbep_pkg::EV_RESET) |-> o_device_address == 7'd0)
        else $error("bus reset left a device address");
`endif

endmodule

### rtl/usbep_ctrl.sv
`timescale 1ns / 1ps
module usbep_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_ready,
    output usbep_pkg::t_dp_cmd o_cmd
);

    usbep_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= usbep_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_ready    = 1'b0;
        o_valid    = 1'b0;
        o_cmd.load = 1'b0;
        o_cmd.exec = 1'b0;
        case (r_state)
            usbep_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = usbep_pkg::S_EXEC;
                end
            end
            usbep_pkg::S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = usbep_pkg::S_OUT;
            end
            usbep_pkg::S_OUT: begin
                o_valid = 1'b1;
                // The result register is free once taken, so a new word may enter.
                if (i_ready) begin
                    o_ready = 1'b1;
                    if (i_valid) begin
                        o_cmd.load = 1'b1;
                        n_state    = usbep_pkg::S_EXEC;
                    end else begin
                        n_state = usbep_pkg::S_IDLE;
                    end
                end
            end
            default: n_state = usbep_pkg::S_IDLE;
        endcase
    end

endmodule

### rtl/usbep_dp.sv
`timescale 1ns / 1ps
module usbep_dp #(
    parameter int EP_COUNT = 8,
    parameter int MAX_PKT  = 64,
    parameter int LEN_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  usbep_pkg::t_dp_cmd i_cmd,
    input  logic               i_cfg_we,
    input  logic [6:0]         i_cfg_data,
    input  logic [3:0]         i_cmd_code,
    input  logic [7:0]         i_endpoint_address,
    input  logic [7:0]         i_endpoint_number,
    input  logic [1:0]         i_endpoint_type,
    input  logic [15:0]        i_transfer_size,
    input  logic [9:0]         i_packet_size,
    input  logic [7:0]         i_rx_length,
    input  logic               i_toggle_ok,
    input  logic [7:0]         i_new_address,
    output logic [2:0]         o_status,
    output logic [2:0]         o_event_kind,
    output logic [7:0]         o_event_endpoint_address,
    output logic [15:0]        o_transferred_count,
    output logic [1:0]         o_handshake,
    output logic [6:0]         o_in_packet_len,
    output logic               o_data_toggle,
    output logic [6:0]         o_device_address,
    output logic [15:0]        o_buffer_offset
);

    localparam int SLOTS = EP_COUNT * 2;
    localparam int SW    = $clog2(SLOTS);
    localparam int EW    = (EP_COUNT > 1) ? $clog2(EP_COUNT) : 1;
    localparam int CW    = (LEN_BITS < 16) ? LEN_BITS : 16;

    logic [SLOTS-1:0]    r_open, r_active, r_toggle;
    logic [1:0]          r_kind   [SLOTS];
    logic [6:0]          r_maxp   [SLOTS];
    logic [LEN_BITS-1:0] r_total  [SLOTS];
    logic [LEN_BITS-1:0] r_done   [SLOTS];
    logic [6:0]          r_queued [SLOTS];
    logic [1:0]          r_resp   [SLOTS];
    logic [6:0]          r_inlen  [EP_COUNT];
    logic                r_apend;
    logic [6:0]          r_paddr, r_caddr, r_ep0mp;

    // Latched command word.
    logic [3:0]  r_c;
    logic [7:0]  r_ea, r_en, r_rx, r_na;
    logic [1:0]  r_ty;
    logic [15:0] r_sz;
    logic [9:0]  r_ps;
    logic        r_tok;

    // Result registers.
    logic [2:0]  r_st, r_ev;
    logic [7:0]  r_eva;
    logic [15:0] r_cnt, r_off;
    logic [1:0]  r_hs;
    logic [6:0]  r_txl;
    logic        r_tg;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_c <= i_cmd_code; r_ea <= i_endpoint_address; r_en <= i_endpoint_number;
            r_ty <= i_endpoint_type; r_sz <= i_transfer_size; r_ps <= i_packet_size;
            r_rx <= i_rx_length; r_tok <= i_toggle_ok; r_na <= i_new_address;
        end
    end

    // Decode.
    logic [3:0]    aep;
    logic          adir, addr_ok, num_ok, has, size_ok;
    logic [SW-1:0] s;
    logic [EW-1:0] ep;
    logic [4:0]    sfull;
    always_comb begin
        aep     = r_ea[3:0];
        adir    = r_ea[7];
        addr_ok = (r_ea[6:4] == 3'd0) && ({28'd0, aep} < EP_COUNT);
        num_ok  = {24'd0, r_en} < EP_COUNT;
        size_ok = (LEN_BITS >= 16) || ((r_sz >> CW) == 16'd0);
        has     = 1'b0;
        sfull   = 5'd0;
        if (r_c <= 4'(usbep_pkg::CMD_CANCEL)) begin
            has = addr_ok; sfull = {aep, adir};
        end else if (r_c == usbep_pkg::CMD_SUBMIT_IN || r_c == usbep_pkg::CMD_IN_DONE) begin
            has = num_ok; sfull = {r_en[3:0], 1'b1};
        end else if (r_c == usbep_pkg::CMD_SUBMIT_OUT || r_c == usbep_pkg::CMD_OUT_RX) begin
            has = num_ok; sfull = {r_en[3:0], 1'b0};
        end else if (r_c == usbep_pkg::CMD_SETUP || r_c == usbep_pkg::CMD_BUS_RESET) begin
            has = 1'b1;
        end
        s  = sfull[SW-1:0];
        ep = sfull[EW:1];
    end

    // Slot values read once.
    logic [LEN_BITS-1:0] cur_total, cur_done, rem, done_in, done_out, ld_rem;
    logic [6:0]          cur_maxp, cur_q, ld_pkt, ld_pkt2;
    always_comb begin
        cur_total = r_total[s];
        cur_done  = r_done[s];
        cur_maxp  = r_maxp[s];
        cur_q     = r_queued[s];
        rem       = cur_total - cur_done;
        done_in   = cur_done + LEN_BITS'(cur_q);
        done_out  = cur_done + LEN_BITS'(r_rx);
        ld_rem    = cur_total - done_in;
        ld_pkt    = (LEN_BITS'(r_sz) > LEN_BITS'(cur_maxp)) ? cur_maxp : 7'(r_sz);
        ld_pkt2   = (ld_rem > LEN_BITS'(cur_maxp)) ? cur_maxp : 7'(ld_rem);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ep0mp <= 7'd64;
        end else if (i_cfg_we && usbep_pkg::pow2_packet({3'd0, i_cfg_data})) begin
            r_ep0mp <= i_cfg_data;
        end
    end

    logic ex;
    assign ex = i_cmd.exec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (ex && r_c == usbep_pkg::CMD_BUS_RESET)) begin
            r_open <= SLOTS'(2'b11); r_active <= '0; r_toggle <= '0;
            for (int k = 0; k < SLOTS; k++) begin
                r_kind[k] <= '0; r_total[k] <= '0;
                r_done[k] <= '0; r_queued[k] <= '0;
                // At power-on the size register is itself being reset, so
                // endpoint zero takes the reset size directly.
                r_maxp[k] <= (k < 2) ? (i_rst_n ? r_ep0mp : 7'd64) : 7'd0;
                r_resp[k] <= (k == 0) ? usbep_pkg::HS_ACK : usbep_pkg::HS_NAK;
            end
            for (int k = 0; k < EP_COUNT; k++) r_inlen[k] <= '0;
            r_apend <= 1'b0; r_paddr <= '0; r_caddr <= '0;
        end else begin
            if (i_cfg_we && usbep_pkg::pow2_packet({3'd0, i_cfg_data})) begin
                r_maxp[0] <= i_cfg_data; r_maxp[1] <= i_cfg_data;
            end
            if (ex) begin
                case (r_c)
                    usbep_pkg::CMD_OPEN: begin
                        if (addr_ok && r_ps != 10'd0 && r_ps <= 10'(MAX_PKT)
                            && !(r_ty == usbep_pkg::KIND_BULK && !usbep_pkg::pow2_packet(r_ps))
                            && aep != 4'd0 && r_ty[1] && !r_open[s]) begin
                            r_open[s] <= 1'b1; r_kind[s] <= r_ty; r_maxp[s] <= r_ps[6:0];
                            r_active[s] <= 1'b0; r_toggle[s] <= 1'b0;
                            r_resp[s] <= usbep_pkg::HS_NAK;
                        end
                    end
                    usbep_pkg::CMD_CLOSE: begin
                        if (addr_ok && aep != 4'd0) begin
                            r_active[s] <= 1'b0; r_total[s] <= '0; r_done[s] <= '0;
                            r_queued[s] <= '0; r_open[s] <= 1'b0; r_kind[s] <= '0;
                            r_maxp[s] <= '0; r_toggle[s] <= 1'b0;
                            r_resp[s] <= usbep_pkg::HS_NAK;
                            if (adir) r_inlen[ep] <= '0;
                        end
                    end
                    usbep_pkg::CMD_STALL, usbep_pkg::CMD_CLR_STALL,
                    usbep_pkg::CMD_CANCEL: begin
                        if (addr_ok && r_open[s]) begin
                            if (r_c == usbep_pkg::CMD_CLR_STALL) begin
                                r_toggle[s] <= 1'b0; r_resp[s] <= usbep_pkg::HS_NAK;
                            end else begin
                                r_active[s] <= 1'b0; r_total[s] <= '0; r_done[s] <= '0;
                                r_queued[s] <= '0;
                                if (adir) r_inlen[ep] <= '0;
                                r_resp[s] <= (r_c == usbep_pkg::CMD_STALL) ?
                                             usbep_pkg::HS_STALL : usbep_pkg::HS_NAK;
                            end
                        end
                    end
                    usbep_pkg::CMD_SUBMIT_IN, usbep_pkg::CMD_SUBMIT_OUT: begin
                        if (num_ok && size_ok && r_open[s] && !r_active[s]) begin
                            r_total[s] <= LEN_BITS'(r_sz); r_done[s] <= '0;
                            r_active[s] <= 1'b1; r_resp[s] <= usbep_pkg::HS_ACK;
                            if (r_c == usbep_pkg::CMD_SUBMIT_IN) begin
                                r_queued[s] <= ld_pkt; r_inlen[ep] <= ld_pkt;
                            end else begin
                                r_queued[s] <= '0;
                            end
                        end
                    end
                    usbep_pkg::CMD_SET_ADDR: begin
                        if (!r_na[7]) begin
                            r_paddr <= r_na[6:0]; r_apend <= 1'b1;
                        end
                    end
                    usbep_pkg::CMD_IN_DONE: begin
                        if (num_ok) begin
                            if (!r_active[s]) begin
                                r_resp[s] <= usbep_pkg::HS_NAK;
                            end else begin
                                r_toggle[s] <= ~r_toggle[s];
                                r_done[s] <= done_in;
                                if (done_in < cur_total) begin
                                    r_queued[s] <= ld_pkt2; r_inlen[ep] <= ld_pkt2;
                                    r_resp[s] <= usbep_pkg::HS_ACK;
                                end else begin
                                    r_queued[s] <= '0; r_active[s] <= 1'b0;
                                    r_resp[s] <= usbep_pkg::HS_NAK;
                                    if (r_en == 8'd0 && r_apend) begin
                                        r_caddr <= r_paddr; r_apend <= 1'b0;
                                    end
                                end
                            end
                        end
                    end
                    usbep_pkg::CMD_OUT_RX: begin
                        if (r_tok && num_ok) begin
                            if (!r_active[s]) begin
                                r_resp[s] <= usbep_pkg::HS_NAK;
                            end else if (LEN_BITS'(r_rx) > rem || r_rx > {1'b0, cur_maxp}) begin
                                r_active[s] <= 1'b0; r_resp[s] <= usbep_pkg::HS_NAK;
                            end else begin
                                r_toggle[s] <= ~r_toggle[s];
                                r_done[s] <= done_out;
                                if (done_out == cur_total || r_rx < {1'b0, cur_maxp}) begin
                                    r_active[s] <= 1'b0; r_resp[s] <= usbep_pkg::HS_NAK;
                                end else begin
                                    r_resp[s] <= usbep_pkg::HS_ACK;
                                end
                            end
                        end
                    end
                    usbep_pkg::CMD_SETUP: begin
                        r_active[0] <= 1'b0; r_active[1] <= 1'b0; r_apend <= 1'b0;
                        r_toggle[0] <= 1'b1; r_toggle[1] <= 1'b1;
                        r_resp[0] <= usbep_pkg::HS_NAK; r_resp[1] <= usbep_pkg::HS_NAK;
                    end
                    default: ;
                endcase
            end
        end
    end

    // Status, event and offset of the command, from the pre-command state.
    logic [2:0]  st, ev;
    logic [7:0]  eva;
    logic [15:0] cnt, off;
    always_comb begin
        st = usbep_pkg::ST_OK; ev = usbep_pkg::EV_NONE; eva = '0; cnt = '0; off = '0;
        case (r_c)
            usbep_pkg::CMD_OPEN: begin
                if (!addr_ok || r_ps == 10'd0 || r_ps > 10'(MAX_PKT)
                    || (r_ty == usbep_pkg::KIND_BULK && !usbep_pkg::pow2_packet(r_ps)))
                    st = usbep_pkg::ST_INVALID;
                else if (aep == 4'd0) st = usbep_pkg::ST_BUSY;
                else if (!r_ty[1]) st = usbep_pkg::ST_UNSUPPORTED;
                else if (r_open[s]) st = usbep_pkg::ST_BUSY;
            end
            usbep_pkg::CMD_CLOSE: begin
                if (!addr_ok) st = usbep_pkg::ST_INVALID;
                else if (aep == 4'd0) st = usbep_pkg::ST_BUSY;
            end
            usbep_pkg::CMD_STALL, usbep_pkg::CMD_CLR_STALL, usbep_pkg::CMD_CANCEL: begin
                if (!addr_ok) st = usbep_pkg::ST_INVALID;
                else if (!r_open[s]) st = usbep_pkg::ST_NOT_READY;
            end
            usbep_pkg::CMD_SUBMIT_IN, usbep_pkg::CMD_SUBMIT_OUT: begin
                if (!num_ok || !size_ok) st = usbep_pkg::ST_INVALID;
                else if (!r_open[s]) st = usbep_pkg::ST_NOT_READY;
                else if (r_active[s]) st = usbep_pkg::ST_BUSY;
            end
            usbep_pkg::CMD_SET_ADDR: begin
                if (r_na[7]) st = usbep_pkg::ST_INVALID;
            end
            usbep_pkg::CMD_IN_DONE: begin
                if (!num_ok) st = usbep_pkg::ST_INVALID;
                else if (r_active[s]) begin
                    if (done_in < cur_total) off = 16'(done_in);
                    else begin
                        ev = usbep_pkg::EV_COMPLETE; eva = {1'b1, r_en[6:0]};
                        cnt = 16'(done_in);
                    end
                end
            end
            usbep_pkg::CMD_OUT_RX: begin
                if (r_tok) begin
                    if (!num_ok) st = usbep_pkg::ST_INVALID;
                    else if (r_active[s]) begin
                        if (LEN_BITS'(r_rx) > rem || r_rx > {1'b0, cur_maxp}) begin
                            ev = usbep_pkg::EV_INVALID; eva = r_en;
                        end else begin
                            off = 16'(cur_done);
                            if (done_out == cur_total || r_rx < {1'b0, cur_maxp}) begin
                                ev = usbep_pkg::EV_COMPLETE; eva = r_en;
                                cnt = 16'(done_out);
                            end
                        end
                    end
                end
            end
            usbep_pkg::CMD_SETUP:     ev = usbep_pkg::EV_SETUP;
            usbep_pkg::CMD_BUS_RESET: ev = usbep_pkg::EV_RESET;
            default: st = usbep_pkg::ST_UNSUPPORTED;
        endcase
    end

    logic r_has;
    logic [SW-1:0] r_s;
    always_ff @(posedge i_clk) begin
        if (ex) begin
            r_st <= st; r_ev <= ev; r_eva <= eva; r_cnt <= cnt; r_off <= off;
            r_has <= has; r_s <= s;
        end
    end

    // Per-slot fields are read after the command updates the state.
    assign o_status                 = r_st;
    assign o_event_kind             = r_ev;
    assign o_event_endpoint_address = r_eva;
    assign o_transferred_count      = r_cnt;
    assign o_buffer_offset          = r_off;
    assign o_handshake              = r_has ? r_resp[r_s] : 2'd0;
    assign o_data_toggle            = r_has ? r_toggle[r_s] : 1'b0;
    assign o_in_packet_len          = r_has ? r_inlen[r_s[SW-1:1]] : 7'd0;
    assign o_device_address         = r_caddr;

    logic unused;
    assign unused = ^{r_kind[0], r_ps[9:7]};

endmodule

### dv/usb_endpoint_transfer_engine_unit_tb.sv
`timescale 1ns / 1ps
module usb_endpoint_transfer_engine_unit_tb;
    import usbep_pkg::*;

    // Limit on consecutive cycles with no word moving on either channel. A
    // correct run never comes near it: the longest quiet stretch is a sender
    // gap plus a receiver stall plus the engine's execute and output states.
    localparam int QUIET_LIMIT = 5000;
    localparam int EP_COUNT    = 8;
    localparam int SLOT_COUNT  = 2 * EP_COUNT;

    // One command word as presented on the command channel.
    typedef struct packed {
        logic [3:0]  cmd;
        logic [7:0]  ep_addr;
        logic [7:0]  ep_num;
        logic [1:0]  ep_type;
        logic [15:0] xfer_size;
        logic [9:0]  pkt_size;
        logic [7:0]  rx_len;
        logic        tog_ok;
        logic [7:0]  new_addr;
    } t_cmd_word;

    // One result word as returned on the result channel.
    typedef struct packed {
        logic [2:0]  status;
        logic [2:0]  ev_kind;
        logic [7:0]  ev_addr;
        logic [15:0] xfer_count;
        logic [1:0]  hs;
        logic [6:0]  tx_len;
        logic        tog;
        logic [6:0]  dev_addr;
        logic [15:0] buf_off;
    } t_ep_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [6:0]  i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [3:0]  i_cmd = '0;
    logic [7:0]  i_endpoint_address = '0;
    logic [7:0]  i_endpoint_number = '0;
    logic [1:0]  i_endpoint_type = '0;
    logic [15:0] i_transfer_size = '0;
    logic [9:0]  i_packet_size = '0;
    logic [7:0]  i_rx_length = '0;
    logic        i_toggle_ok = 1'b0;
    logic [7:0]  i_new_address = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [2:0]  o_status;
    logic [2:0]  o_event_kind;
    logic [7:0]  o_event_endpoint_address;
    logic [15:0] o_transferred_count;
    logic [1:0]  o_handshake;
    logic [6:0]  o_in_packet_len;
    logic        o_data_toggle;
    logic [6:0]  o_device_address;
    logic [15:0] o_buffer_offset;

    usb_endpoint_transfer_engine_unit uut (
        .i_clk                    (i_clk),
        .i_rst_n                  (i_rst_n),
        .i_cfg_we                 (i_cfg_we),
        .i_cfg_data               (i_cfg_data),
        .i_valid                  (i_valid),
        .o_ready                  (o_ready),
        .i_cmd                    (i_cmd),
        .i_endpoint_address       (i_endpoint_address),
        .i_endpoint_number        (i_endpoint_number),
        .i_endpoint_type          (i_endpoint_type),
        .i_transfer_size          (i_transfer_size),
        .i_packet_size            (i_packet_size),
        .i_rx_length              (i_rx_length),
        .i_toggle_ok              (i_toggle_ok),
        .i_new_address            (i_new_address),
        .o_valid                  (o_valid),
        .i_ready                  (i_ready),
        .o_status                 (o_status),
        .o_event_kind             (o_event_kind),
        .o_event_endpoint_address (o_event_endpoint_address),
        .o_transferred_count      (o_transferred_count),
        .o_handshake              (o_handshake),
        .o_in_packet_len          (o_in_packet_len),
        .o_data_toggle            (o_data_toggle),
        .o_device_address         (o_device_address),
        .o_buffer_offset          (o_buffer_offset)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the endpoint state. A slot is endpoint * 2 + direction,
    // with direction 1 meaning IN, exactly as the block indexes it.
    logic [6:0]  ep0_mps;
    logic        ep_is_open [SLOT_COUNT];
    logic [1:0]  ep_kind_q  [SLOT_COUNT];
    logic [6:0]  ep_mps     [SLOT_COUNT];
    logic        xf_busy    [SLOT_COUNT];
    int unsigned xf_len     [SLOT_COUNT];
    int unsigned xf_sent    [SLOT_COUNT];
    int unsigned xf_pend    [SLOT_COUNT];
    logic [1:0]  ep_hs      [SLOT_COUNT];
    logic        ep_tog     [SLOT_COUNT];
    logic [6:0]  ep_in_len  [EP_COUNT];
    logic        addr_armed;
    logic [6:0]  addr_next;
    logic [6:0]  dev_addr_q;

    t_ep_result  expected_results [$];
    int          error_count = 0;
    int          words_sent = 0;
    int          results_seen = 0;
    int          completions_seen = 0;
    int          quiet_cycles = 0;
    bit          idling_on = 1'b1;

    function automatic bit legal_mps(input int unsigned v);
        return v == 8 || v == 16 || v == 32 || v == 64;
    endfunction

    // Bus reset and power-on both return every endpoint to its default; the
    // applied device address is cleared separately by the caller.
    task automatic restore_endpoints();
        for (int s = 0; s < SLOT_COUNT; s++) begin
            ep_is_open[s] = 1'b0;
            ep_kind_q[s]  = KIND_CONTROL;
            ep_mps[s]     = '0;
            xf_busy[s]    = 1'b0;
            xf_len[s]     = 0;
            xf_sent[s]    = 0;
            xf_pend[s]    = 0;
            ep_hs[s]      = HS_NAK;
            ep_tog[s]     = 1'b0;
        end
        for (int e = 0; e < EP_COUNT; e++) ep_in_len[e] = '0;
        ep_is_open[0] = 1'b1;
        ep_is_open[1] = 1'b1;
        ep_mps[0] = ep0_mps;
        ep_mps[1] = ep0_mps;
        ep_hs[0] = HS_ACK;
        addr_armed = 1'b0;
        addr_next = '0;
    endtask

    // Queue the next piece of an IN transfer: at most one max packet.
    task automatic queue_in_piece(input int ep);
        int s;
        int unsigned left;
        s = ep * 2 + 1;
        left = xf_len[s] - xf_sent[s];
        if (left > ep_mps[s]) left = ep_mps[s];
        xf_pend[s] = left;
        ep_in_len[ep] = left[6:0];
        ep_hs[s] = HS_ACK;
    endtask

    task automatic apply_ep0_mps(input logic [6:0] v);
        if (legal_mps(v)) begin
            ep0_mps = v;
            ep_mps[0] = v;
            ep_mps[1] = v;
        end
    endtask

    // Advance the shadow state by one command and produce its result word.
    task automatic predict_endpoint_result(input t_cmd_word w, output t_ep_result r);
        int          aep;
        int          adir;
        int          s;
        bit          addr_ok;
        bit          num_ok;
        bit          has_dir;
        int unsigned rx;
        rx = w.rx_len;
        aep = w.ep_addr[3:0];
        adir = w.ep_addr[7];
        addr_ok = (w.ep_addr[6:4] == 3'd0) && (aep < EP_COUNT);
        num_ok = w.ep_num < EP_COUNT;
        has_dir = 1'b0;
        s = 0;
        r = '0;

        // Work out which endpoint direction the command touches.
        if (w.cmd <= CMD_CANCEL) begin
            has_dir = addr_ok;
            s = aep * 2 + adir;
        end else if (w.cmd == CMD_SUBMIT_IN || w.cmd == CMD_IN_DONE) begin
            has_dir = num_ok;
            s = w.ep_num * 2 + 1;
        end else if (w.cmd == CMD_SUBMIT_OUT || w.cmd == CMD_OUT_RX) begin
            has_dir = num_ok;
            s = w.ep_num * 2;
        end else if (w.cmd == CMD_SETUP || w.cmd == CMD_BUS_RESET) begin
            has_dir = 1'b1;
            s = 0;
        end
        if (!has_dir) s = 0;

        case (w.cmd)
            CMD_OPEN: begin
                if (!addr_ok || w.pkt_size == 0 || w.pkt_size > 64 ||
                    (w.ep_type == KIND_BULK && !legal_mps(w.pkt_size)))
                    r.status = ST_INVALID;
                else if (aep == 0)
                    r.status = ST_BUSY;
                else if (w.ep_type == KIND_CONTROL || w.ep_type == KIND_ISO)
                    r.status = ST_UNSUPPORTED;
                else if (ep_is_open[s])
                    r.status = ST_BUSY;
                else begin
                    ep_is_open[s] = 1'b1;
                    ep_kind_q[s] = w.ep_type;
                    ep_mps[s] = w.pkt_size[6:0];
                    xf_busy[s] = 1'b0;
                    ep_tog[s] = 1'b0;
                    ep_hs[s] = HS_NAK;
                end
            end
            CMD_CLOSE: begin
                if (!addr_ok)
                    r.status = ST_INVALID;
                else if (aep == 0)
                    r.status = ST_BUSY;
                else begin
                    xf_busy[s] = 1'b0;
                    xf_len[s] = 0;
                    xf_sent[s] = 0;
                    xf_pend[s] = 0;
                    ep_is_open[s] = 1'b0;
                    ep_kind_q[s] = KIND_CONTROL;
                    ep_mps[s] = '0;
                    if (adir) ep_in_len[aep] = '0;
                    ep_tog[s] = 1'b0;
                    ep_hs[s] = HS_NAK;
                end
            end
            CMD_STALL, CMD_CLR_STALL, CMD_CANCEL: begin
                if (!addr_ok)
                    r.status = ST_INVALID;
                else if (!ep_is_open[s])
                    r.status = ST_NOT_READY;
                else if (w.cmd == CMD_CLR_STALL) begin
                    ep_tog[s] = 1'b0;
                    ep_hs[s] = HS_NAK;
                end else begin
                    xf_busy[s] = 1'b0;
                    xf_len[s] = 0;
                    xf_sent[s] = 0;
                    xf_pend[s] = 0;
                    if (adir) ep_in_len[aep] = '0;
                    ep_hs[s] = (w.cmd == CMD_STALL) ? HS_STALL : HS_NAK;
                end
            end
            CMD_SUBMIT_IN, CMD_SUBMIT_OUT: begin
                // A 16-bit size always fits the transfer counters here.
                if (!num_ok)
                    r.status = ST_INVALID;
                else if (!ep_is_open[s])
                    r.status = ST_NOT_READY;
                else if (xf_busy[s])
                    r.status = ST_BUSY;
                else begin
                    xf_len[s] = w.xfer_size;
                    xf_sent[s] = 0;
                    xf_pend[s] = 0;
                    xf_busy[s] = 1'b1;
                    if (w.cmd == CMD_SUBMIT_IN)
                        queue_in_piece(w.ep_num);
                    else
                        ep_hs[s] = HS_ACK;
                end
            end
            CMD_SET_ADDR: begin
                if (w.new_addr > 127)
                    r.status = ST_INVALID;
                else begin
                    addr_next = w.new_addr[6:0];
                    addr_armed = 1'b1;
                end
            end
            CMD_IN_DONE: begin
                if (!num_ok)
                    r.status = ST_INVALID;
                else if (!xf_busy[s])
                    ep_hs[s] = HS_NAK;
                else begin
                    ep_tog[s] = ~ep_tog[s];
                    xf_sent[s] += xf_pend[s];
                    xf_pend[s] = 0;
                    if (xf_sent[s] < xf_len[s]) begin
                        r.buf_off = 16'(xf_sent[s]);
                        queue_in_piece(w.ep_num);
                    end else begin
                        xf_busy[s] = 1'b0;
                        ep_hs[s] = HS_NAK;
                        // The status stage of SET_ADDRESS is an endpoint-zero
                        // IN completion; that is when the new address takes hold.
                        if (w.ep_num == 0 && addr_armed) begin
                            dev_addr_q = addr_next;
                            addr_armed = 1'b0;
                        end
                        r.ev_kind = EV_COMPLETE;
                        r.ev_addr = 8'h80 | w.ep_num;
                        r.xfer_count = 16'(xf_sent[s]);
                    end
                end
            end
            CMD_OUT_RX: begin
                // A packet with the wrong toggle is a retry and is dropped.
                if (w.tog_ok) begin
                    if (!num_ok)
                        r.status = ST_INVALID;
                    else if (!xf_busy[s])
                        ep_hs[s] = HS_NAK;
                    else if (rx > xf_len[s] - xf_sent[s] || rx > ep_mps[s]) begin
                        xf_busy[s] = 1'b0;
                        ep_hs[s] = HS_NAK;
                        r.ev_kind = EV_INVALID;
                        r.ev_addr = w.ep_num;
                    end else begin
                        r.buf_off = 16'(xf_sent[s]);
                        ep_tog[s] = ~ep_tog[s];
                        xf_sent[s] += rx;
                        if (xf_sent[s] == xf_len[s] || rx < ep_mps[s]) begin
                            xf_busy[s] = 1'b0;
                            ep_hs[s] = HS_NAK;
                            r.ev_kind = EV_COMPLETE;
                            r.ev_addr = w.ep_num;
                            r.xfer_count = 16'(xf_sent[s]);
                        end else
                            ep_hs[s] = HS_ACK;
                    end
                end
            end
            CMD_SETUP: begin
                xf_busy[0] = 1'b0;
                xf_busy[1] = 1'b0;
                addr_armed = 1'b0;
                ep_tog[0] = 1'b1;
                ep_tog[1] = 1'b1;
                ep_hs[0] = HS_NAK;
                ep_hs[1] = HS_NAK;
                r.ev_kind = EV_SETUP;
            end
            CMD_BUS_RESET: begin
                dev_addr_q = '0;
                restore_endpoints();
                r.ev_kind = EV_RESET;
            end
            default: r.status = ST_UNSUPPORTED;
        endcase

        if (has_dir) begin
            r.hs = ep_hs[s];
            r.tx_len = ep_in_len[s >> 1];
            r.tog = ep_tog[s];
        end
        r.dev_addr = dev_addr_q;
    endtask

    task automatic report_mismatch(input string field, input int want, input int got);
        $display("%0t: result %0d field %s expected %0d got %0d",
                 $realtime, results_seen, field, want, got);
        error_count++;
    endtask

    // Present one command word, hold it until accepted, then record what the
    // engine should answer. Valid is left high so that a following word can
    // go out back to back; every caller that pauses lowers it at once.
    task automatic send_word(input t_cmd_word w);
        t_ep_result r;
        i_valid            <= 1'b1;
        i_cmd              <= w.cmd;
        i_endpoint_address <= w.ep_addr;
        i_endpoint_number  <= w.ep_num;
        i_endpoint_type    <= w.ep_type;
        i_transfer_size    <= w.xfer_size;
        i_packet_size      <= w.pkt_size;
        i_rx_length        <= w.rx_len;
        i_toggle_ok        <= w.tog_ok;
        i_new_address      <= w.new_addr;
        do @(posedge i_clk); while (!o_ready);
        predict_endpoint_result(w, r);
        expected_results.push_back(r);
        words_sent++;
        if (idling_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
    endtask

    function automatic t_cmd_word mkw(input logic [3:0] c, input logic [7:0] a,
                                      input logic [7:0] n, input logic [1:0] t,
                                      input logic [15:0] sz, input logic [9:0] ps,
                                      input logic [7:0] rx, input logic tk,
                                      input logic [7:0] na);
        t_cmd_word w;
        w = '{c, a, n, t, sz, ps, rx, tk, na};
        return w;
    endfunction

    // The register may only change while the engine is idle, so drain every
    // outstanding result and let the pipeline settle first.
    task automatic write_ep0_mps(input logic [6:0] v);
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        apply_ep0_mps(v);
        @(posedge i_clk);
    endtask

    // Random command word. Addresses and numbers are mostly legal so that
    // endpoints actually open and transfers run; a slice of every field is
    // drawn from its whole range so each bit is exercised.
    function automatic t_cmd_word random_word();
        t_cmd_word  w;
        int         pick;
        logic [6:0] sizes [4];
        sizes = '{7'd8, 7'd16, 7'd32, 7'd64};
        w = '0;
        pick = $urandom_range(0, 99);
        if (pick < 10)       w.cmd = CMD_OPEN;
        else if (pick < 13)  w.cmd = CMD_CLOSE;
        else if (pick < 15)  w.cmd = CMD_STALL;
        else if (pick < 17)  w.cmd = CMD_CLR_STALL;
        else if (pick < 19)  w.cmd = CMD_CANCEL;
        else if (pick < 31)  w.cmd = CMD_SUBMIT_IN;
        else if (pick < 43)  w.cmd = CMD_SUBMIT_OUT;
        else if (pick < 46)  w.cmd = CMD_SET_ADDR;
        else if (pick < 68)  w.cmd = CMD_IN_DONE;
        else if (pick < 92)  w.cmd = CMD_OUT_RX;
        else if (pick < 95)  w.cmd = CMD_SETUP;
        else if (pick < 96)  w.cmd = CMD_BUS_RESET;
        else                 w.cmd = 4'($urandom_range(0, 15));
        if ($urandom_range(0, 9) == 0)
            w.ep_addr = 8'($urandom_range(0, 255));
        else
            w.ep_addr = {$urandom_range(0, 1) == 1, 4'd0, 3'($urandom_range(0, 7))};
        w.ep_num = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255))
                                                 : 8'($urandom_range(0, EP_COUNT - 1));
        w.ep_type = ($urandom_range(0, 3) == 0) ? 2'($urandom_range(0, 3))
                                                : ($urandom_range(0, 1) ? 2'd2 : 2'd3);
        case ($urandom_range(0, 9))
            0:       w.xfer_size = 16'($urandom_range(0, 65535));
            1, 2:    w.xfer_size = 16'd0;
            default: w.xfer_size = 16'($urandom_range(1, 300));
        endcase
        w.pkt_size = ($urandom_range(0, 4) == 0) ? 10'($urandom_range(0, 1023))
                                                 : 10'(sizes[$urandom_range(0, 3)]);
        case ($urandom_range(0, 3))
            0:       w.rx_len = 8'($urandom_range(0, 255));
            1:       w.rx_len = 8'($urandom_range(0, 64));
            default: w.rx_len = 8'(sizes[$urandom_range(0, 3)]);
        endcase
        w.tog_ok = ($urandom_range(0, 7) != 0);
        w.new_addr = 8'($urandom_range(0, 255));
        return w;
    endfunction

    // Receiver side: random stall bursts while idling is enabled.
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (!idling_on) begin
            i_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_ready <= (stall_left == 1);
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(1, 10);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Result checker and watchdog.
    always @(posedge i_clk) begin
        t_ep_result want;
        if ((i_valid && o_ready) || (o_valid && i_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("outstanding_results", 0, 1);
            end else begin
                want = expected_results.pop_front();
                if (o_status != want.status)
                    report_mismatch("status", want.status, o_status);
                if (o_event_kind != want.ev_kind)
                    report_mismatch("event_kind", want.ev_kind, o_event_kind);
                if (o_event_endpoint_address != want.ev_addr)
                    report_mismatch("event_endpoint_address", want.ev_addr,
                                    o_event_endpoint_address);
                if (o_transferred_count != want.xfer_count)
                    report_mismatch("transferred_count", want.xfer_count,
                                    o_transferred_count);
                if (o_handshake != want.hs)
                    report_mismatch("handshake", want.hs, o_handshake);
                if (o_in_packet_len != want.tx_len)
                    report_mismatch("in_packet_len", want.tx_len, o_in_packet_len);
                if (o_data_toggle != want.tog)
                    report_mismatch("data_toggle", want.tog, o_data_toggle);
                if (o_device_address != want.dev_addr)
                    report_mismatch("device_address", want.dev_addr, o_device_address);
                if (o_buffer_offset != want.buf_off)
                    report_mismatch("buffer_offset", want.buf_off, o_buffer_offset);
                if (want.ev_kind == EV_COMPLETE) completions_seen++;
            end
            results_seen++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $realtime, QUIET_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Edge cases of the open command, a close of endpoint zero, a stall of an
    // endpoint that is not open, plus the commands the engine does not know.
    task automatic test_open_and_bad_args();
        send_word(mkw(CMD_OPEN, 8'h81, 0, KIND_BULK, 0, 0, 0, 1, 0));
        send_word(mkw(CMD_OPEN, 8'h81, 0, KIND_BULK, 0, 10'd1023, 0, 1, 0));
        send_word(mkw(CMD_OPEN, 8'h81, 0, KIND_BULK, 0, 10'd65, 0, 1, 0));
        send_word(mkw(CMD_OPEN, 8'h81, 0, KIND_BULK, 0, 10'd24, 0, 1, 0));
        send_word(mkw(CMD_OPEN, 8'hF1, 0, KIND_BULK, 0, 10'd64, 0, 1, 0));
        send_word(mkw(CMD_OPEN, 8'h8F, 0, KIND_BULK, 0, 10'd64, 0, 1, 0));
        send_word(mkw(CMD_OPEN, 8'h80, 0, KIND_BULK, 0, 10'd64, 0, 1, 0));
        send_word(mkw(CMD_OPEN, 8'h82, 0, KIND_ISO, 0, 10'd64, 0, 1, 0));
        send_word(mkw(CMD_OPEN, 8'h82, 0, KIND_CONTROL, 0, 10'd64, 0, 1, 0));
        send_word(mkw(CMD_OPEN, 8'h81, 0, KIND_BULK, 0, 10'd16, 0, 1, 0));
        send_word(mkw(CMD_OPEN, 8'h81, 0, KIND_BULK, 0, 10'd16, 0, 1, 0));
        send_word(mkw(CMD_OPEN, 8'h02, 0, 2'd3, 0, 10'd7, 0, 1, 0));
        send_word(mkw(CMD_CLOSE, 8'h00, 0, 0, 0, 0, 0, 1, 0));
        send_word(mkw(CMD_STALL, 8'h03, 0, 0, 0, 0, 0, 1, 0));
        for (int c = 12; c < 16; c++)
            send_word(mkw(4'(c), 8'hFF, 8'hFF, 2'd3, 16'hFFFF, 10'h3FF, 8'hFF, 1, 8'hFF));
    endtask

    // Address change completing on the endpoint-zero status stage, an IN
    // transfer split into pieces, and OUT transfers ended by an invalid event.
    task automatic test_transfers();
        send_word(mkw(CMD_SET_ADDR, 0, 0, 0, 0, 0, 0, 1, 8'd200));
        send_word(mkw(CMD_SET_ADDR, 0, 0, 0, 0, 0, 0, 1, 8'd127));
        send_word(mkw(CMD_SUBMIT_IN, 0, 8'd0, 0, 16'd100, 0, 0, 1, 0));
        send_word(mkw(CMD_SUBMIT_IN, 0, 8'd0, 0, 16'd100, 0, 0, 1, 0));
        send_word(mkw(CMD_IN_DONE, 0, 8'd0, 0, 0, 0, 0, 1, 0));
        send_word(mkw(CMD_IN_DONE, 0, 8'd0, 0, 0, 0, 0, 1, 0));
        send_word(mkw(CMD_IN_DONE, 0, 8'd0, 0, 0, 0, 0, 1, 0));
        send_word(mkw(CMD_IN_DONE, 0, 8'hFF, 0, 0, 0, 0, 1, 0));
        send_word(mkw(CMD_SUBMIT_OUT, 0, 8'd0, 0, 16'd80, 0, 0, 1, 0));
        send_word(mkw(CMD_OUT_RX, 0, 8'd0, 0, 0, 0, 8'd64, 0, 0));
        send_word(mkw(CMD_OUT_RX, 0, 8'd0, 0, 0, 0, 8'd64, 1, 0));
        send_word(mkw(CMD_OUT_RX, 0, 8'd0, 0, 0, 0, 8'd20, 1, 0));
        send_word(mkw(CMD_SUBMIT_OUT, 0, 8'd0, 0, 16'd10, 0, 0, 1, 0));
        send_word(mkw(CMD_OUT_RX, 0, 8'd0, 0, 0, 0, 8'd255, 1, 0));
        send_word(mkw(CMD_OUT_RX, 0, 8'd0, 0, 0, 0, 8'd3, 1, 0));
        send_word(mkw(CMD_OUT_RX, 0, 8'hFF, 0, 0, 0, 8'd3, 1, 0));
        send_word(mkw(CMD_SUBMIT_OUT, 0, 8'd9, 0, 16'd10, 0, 0, 1, 0));
        send_word(mkw(CMD_SUBMIT_IN, 0, 8'd5, 0, 16'hFFFF, 0, 0, 1, 0));
        send_word(mkw(CMD_CANCEL, 8'h81, 0, 0, 0, 0, 0, 1, 0));
        send_word(mkw(CMD_CLR_STALL, 8'h81, 0, 0, 0, 0, 0, 1, 0));
        send_word(mkw(CMD_SETUP, 0, 0, 0, 0, 0, 0, 1, 0));
        send_word(mkw(CMD_BUS_RESET, 0, 0, 0, 0, 0, 0, 1, 0));
    endtask

    task automatic test_random_traffic(input int count);
        for (int k = 0; k < count; k++) send_word(random_word());
    endtask

    initial begin
        ep0_mps = 7'd64;
        dev_addr_q = '0;
        restore_endpoints();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_ep0_mps(7'd64);
        test_open_and_bad_args();
        test_transfers();
        write_ep0_mps(7'd8);
        test_random_traffic(500);
        write_ep0_mps(7'd100);
        write_ep0_mps(7'd127);
        write_ep0_mps(7'd0);
        test_random_traffic(500);
        write_ep0_mps(7'd32);
        test_random_traffic(500);
        // Last stretch runs at full rate with neither side idling.
        write_ep0_mps(7'd16);
        idling_on = 1'b0;
        test_random_traffic(500);
        i_valid <= 1'b0;

        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Sent %0d command words and checked %0d result words,", words_sent,
                 results_seen);
        $display("with %0d transfer completions over four endpoint-zero packet sizes.",
                 completions_seen);
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", error_count);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
